### rtl/pts_pkg.sv
// Shared types, codes and helpers for the Prolog token scanner.
package pts_pkg;

  localparam int MAX_TOKEN = 256;
  localparam int CNT_W     = $clog2(MAX_TOKEN + 1);
  localparam int QDEPTH    = 8;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int WR_MAX    = 3;

  localparam logic [2:0] CLS_ILLEGAL = 3'd0;
  localparam logic [2:0] CLS_WORD    = 3'd1;
  localparam logic [2:0] CLS_DIGIT   = 3'd2;
  localparam logic [2:0] CLS_SYMBOL  = 3'd3;
  localparam logic [2:0] CLS_PUNCT   = 3'd4;
  localparam logic [2:0] CLS_QUOTE   = 3'd5;
  localparam logic [2:0] CLS_STRDEL  = 3'd6;
  localparam logic [2:0] CLS_SPACE   = 3'd7;

  localparam logic [3:0] TOK_WORD    = 4'd0;
  localparam logic [3:0] TOK_SYMBOL  = 4'd1;
  localparam logic [3:0] TOK_PUNCT   = 4'd2;
  localparam logic [3:0] TOK_QUOTED  = 4'd3;
  localparam logic [3:0] TOK_STRING  = 4'd4;
  localparam logic [3:0] TOK_INT     = 4'd5;
  localparam logic [3:0] TOK_REAL    = 4'd6;
  localparam logic [3:0] TOK_END     = 4'd7;
  localparam logic [3:0] TOK_ILLEGAL = 4'd8;

  localparam logic RK_CHAR = 1'b0;
  localparam logic RK_END  = 1'b1;

  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LN     = 8'h6e;
  localparam logic [7:0] CH_LT     = 8'h74;

  typedef enum logic [16:0] {
    S_START  = 17'h00001,
    S_IDENT  = 17'h00002,
    S_SLASH  = 17'h00004,
    S_SYMB   = 17'h00008,
    S_LCOMM  = 17'h00010,
    S_COMM   = 17'h00020,
    S_CSTAR  = 17'h00040,
    S_QATOM  = 17'h00080,
    S_QQUOTE = 17'h00100,
    S_STRING = 17'h00200,
    S_SESC   = 17'h00400,
    S_INT    = 17'h00800,
    S_FRAC   = 17'h01000,
    S_REAL   = 17'h02000,
    S_E      = 17'h04000,
    S_EXP    = 17'h08000,
    S_EXPRST = 17'h10000
  } scan_state_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic [2:0] char_class;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] out_char;
    logic [3:0] token_type;
    logic       truncated;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]        count;
    res_t [WR_MAX-1:0] data;
  } wr_t;

  function automatic res_t mk_char(input logic [7:0] ch);
    res_t r;
    r = '0;
    r.result_kind = RK_CHAR;
    r.out_char = ch;
    return r;
  endfunction

  function automatic res_t mk_end(input logic [3:0] typ, input logic trunc);
    res_t r;
    r = '0;
    r.result_kind = RK_END;
    r.token_type = typ;
    r.truncated = trunc;
    return r;
  endfunction

endpackage

### rtl/prolog_token_scanner.sv
// Top level of the Prolog token scanner: scanner front end and result queue.
//
// Input channel: one word per character, with its class, or an end-of-input
// marker. A word is taken at a clock edge where push is high and full is low.
// Result channel: the oldest result word is on result while empty is low and
// leaves at an edge where pop is high. Each result is a token character or a
// token end with its type; the final result of an input word carries last.
// The scanner makes one scan pass per cycle. Most characters are done in
// the pass that first scans them, so a new character is taken every cycle;
// a character that closes a token is scanned again, and a pushed-back dot or
// exponent letter is scanned before the character after it. A pass runs only
// when the eight-entry result queue has room for three words, so a stalled
// receiver stops the scanner and then full rises. Each pass writes its results
// to the queue, but the newest result of an unfinished input word waits for
// the pass that ends that word. Reset returns the scanner to its start state
// and empties the queue; the block takes words in the first cycle after reset.
module prolog_token_scanner (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  pts_pkg::item_t item,
  output logic           empty,
  input  logic           pop,
  output pts_pkg::res_t  result
);
  import pts_pkg::*;

  wr_t  wr;
  logic room;

  pts_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .item (item),
    .room (room),
    .wr   (wr)
  );

  pts_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .room   (room),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

### rtl/pts_front.sv
// Scanner front end: holds the current character and runs one scan pass per cycle.
module pts_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  pts_pkg::item_t item,
  input  logic           room,
  output pts_pkg::wr_t   wr
);
  import pts_pkg::*;

  typedef enum logic [1:0] {F_DONE, F_AGAIN, F_SAVED} feed_ret_t;

  item_t                  cur;
  logic                   cur_valid;
  scan_state_t            st;
  logic [CNT_W-1:0]       cnt;
  logic                   ovf;
  logic [2:0]             ecl;
  logic                   saved_mode;
  logic [7:0]             saved_char;
  logic [2:0]             saved_class;
  res_t                   hold;
  logic                   hold_valid;

  logic [7:0]             fc;
  logic [2:0]             fcls;
  logic                   feof;
  logic                   is_e;
  scan_state_t            st_dec;
  logic [1:0]             acc_n;
  logic [7:0]             a0;
  logic [7:0]             a1;
  logic                   do_end;
  logic [3:0]             end_type;
  feed_ret_t              ret;
  logic                   ecl_set;
  logic                   sv_set;
  logic [7:0]             sv_char;
  logic [2:0]             sv_class;

  logic [CNT_W-1:0]       cnt_a;
  logic                   ovf_a;
  res_t [1:0]             nr;
  logic [1:0]             n;
  res_t [WR_MAX-1:0]      lst;
  logic [1:0]             lcnt;
  res_t                   hold_next;
  logic                   hold_valid_next;

  logic                   step;
  logic                   final_step;

  assign fc   = saved_mode ? saved_char : cur.in_char;
  assign fcls = saved_mode ? saved_class : cur.char_class;
  assign feof = saved_mode ? 1'b0 : cur.end_of_input;
  assign is_e = (fc == CH_LE) || (fc == CH_UE);

  always_comb begin
    st_dec   = st;
    acc_n    = 2'd0;
    a0       = fc;
    a1       = fc;
    do_end   = 1'b0;
    end_type = TOK_WORD;
    ret      = F_DONE;
    ecl_set  = 1'b0;
    sv_set   = 1'b0;
    sv_char  = CH_DOT;
    sv_class = CLS_SYMBOL;
    case (st)
      S_IDENT: begin
        if (!feof && (fcls == CLS_WORD || fcls == CLS_DIGIT)) begin
          acc_n = 2'd1;
        end else begin
          do_end = 1'b1; end_type = TOK_WORD; ret = F_AGAIN;
        end
      end
      S_SLASH: begin
        if (!feof && fc == CH_STAR) begin
          st_dec = S_COMM;
        end else begin
          acc_n = 2'd1; a0 = CH_SLASH; st_dec = S_SYMB; ret = F_AGAIN;
        end
      end
      S_SYMB: begin
        if (!feof && fcls == CLS_SYMBOL) begin
          acc_n = 2'd1;
        end else begin
          do_end = 1'b1; end_type = TOK_SYMBOL; ret = F_AGAIN;
        end
      end
      S_LCOMM: begin
        if (feof) begin
          st_dec = S_START; ret = F_AGAIN;
        end else if (fc == CH_NL) begin
          st_dec = S_START;
        end
      end
      S_COMM: begin
        if (feof) begin
          st_dec = S_START; ret = F_AGAIN;
        end else if (fc == CH_STAR) begin
          st_dec = S_CSTAR;
        end
      end
      S_CSTAR: begin
        if (feof) begin
          st_dec = S_START; ret = F_AGAIN;
        end else begin
          st_dec = (fc == CH_SLASH) ? S_START : S_COMM;
        end
      end
      S_QATOM: begin
        if (feof) begin
          do_end = 1'b1; end_type = TOK_ILLEGAL; ret = F_AGAIN;
        end else if (fcls == CLS_QUOTE) begin
          st_dec = S_QQUOTE;
        end else begin
          acc_n = 2'd1;
        end
      end
      S_QQUOTE: begin
        if (!feof && fc == CH_QUOTE) begin
          acc_n = 2'd1; st_dec = S_QATOM;
        end else begin
          do_end = 1'b1; end_type = TOK_QUOTED; ret = F_AGAIN;
        end
      end
      S_STRING: begin
        if (feof) begin
          do_end = 1'b1; end_type = TOK_ILLEGAL; ret = F_AGAIN;
        end else if (fcls == CLS_STRDEL) begin
          do_end = 1'b1; end_type = TOK_STRING;
        end else if (fcls == CLS_SYMBOL && fc == CH_BSLASH) begin
          st_dec = S_SESC;
        end else begin
          acc_n = 2'd1;
        end
      end
      S_SESC: begin
        if (feof) begin
          do_end = 1'b1; end_type = TOK_ILLEGAL; ret = F_AGAIN;
        end else begin
          acc_n = 2'd1;
          st_dec = S_STRING;
          if (fc == CH_LB) begin
            a0 = CH_BEL;
          end else if (fc == CH_LN) begin
            a0 = CH_NL;
          end else if (fc == CH_LT) begin
            a0 = CH_TAB;
          end
        end
      end
      S_INT: begin
        if (!feof && fcls == CLS_DIGIT) begin
          acc_n = 2'd1;
        end else if (!feof && fcls == CLS_SYMBOL && fc == CH_DOT) begin
          st_dec = S_FRAC;
        end else if (!feof && (fcls == CLS_SYMBOL || fcls == CLS_WORD) && is_e) begin
          ecl_set = 1'b1; st_dec = S_E;
        end else begin
          do_end = 1'b1; end_type = TOK_INT; ret = F_AGAIN;
        end
      end
      S_FRAC: begin
        if (!feof && fcls == CLS_DIGIT) begin
          acc_n = 2'd2; a0 = CH_DOT; st_dec = S_REAL;
        end else begin
          do_end = 1'b1; end_type = TOK_INT; ret = F_SAVED;
          sv_set = 1'b1; sv_char = CH_DOT; sv_class = CLS_SYMBOL;
        end
      end
      S_REAL: begin
        if (!feof && fcls == CLS_DIGIT) begin
          acc_n = 2'd1;
        end else if (!feof && fcls == CLS_WORD && is_e) begin
          ecl_set = 1'b1; st_dec = S_E;
        end else begin
          do_end = 1'b1; end_type = TOK_REAL; ret = F_AGAIN;
        end
      end
      S_E: begin
        if (!feof && fcls == CLS_DIGIT) begin
          acc_n = 2'd2; a0 = CH_LE; st_dec = S_EXPRST;
        end else if (!feof && fcls == CLS_SYMBOL && (fc == CH_PLUS || fc == CH_MINUS)) begin
          acc_n = 2'd2; a0 = CH_LE; st_dec = S_EXP;
        end else begin
          do_end = 1'b1; end_type = TOK_REAL; ret = F_SAVED;
          sv_set = 1'b1; sv_char = CH_LE; sv_class = ecl;
        end
      end
      S_EXP: begin
        if (!feof && fcls == CLS_DIGIT) begin
          acc_n = 2'd1; st_dec = S_EXPRST;
        end else begin
          do_end = 1'b1; end_type = TOK_ILLEGAL;
          ret = feof ? F_AGAIN : F_DONE;
        end
      end
      S_EXPRST: begin
        if (!feof && fcls == CLS_DIGIT) begin
          acc_n = 2'd1;
        end else begin
          do_end = 1'b1; end_type = TOK_REAL; ret = F_AGAIN;
        end
      end
      default: begin
        st_dec = S_START;
        if (feof) begin
          do_end = 1'b1; end_type = TOK_END;
        end else begin
          case (fcls)
            CLS_WORD: begin
              acc_n = 2'd1; st_dec = S_IDENT;
            end
            CLS_DIGIT: begin
              acc_n = 2'd1; st_dec = S_INT;
            end
            CLS_SYMBOL: begin
              if (fc == CH_PCT) begin
                st_dec = S_LCOMM;
              end else if (fc == CH_SLASH) begin
                st_dec = S_SLASH;
              end else begin
                acc_n = 2'd1; st_dec = S_SYMB;
              end
            end
            CLS_PUNCT: begin
              acc_n = 2'd1; do_end = 1'b1; end_type = TOK_PUNCT;
            end
            CLS_QUOTE:  st_dec = S_QATOM;
            CLS_STRDEL: st_dec = S_STRING;
            CLS_SPACE:  st_dec = S_START;
            default: begin
              do_end = 1'b1; end_type = TOK_ILLEGAL;
            end
          endcase
        end
      end
    endcase
  end

  // Accepted characters come first, then the token end, which reports the overflow.
  always_comb begin
    cnt_a = cnt;
    ovf_a = ovf;
    nr    = '0;
    n     = 2'd0;
    if (acc_n != 2'd0) begin
      if (cnt_a < CNT_W'(MAX_TOKEN)) begin
        nr[0] = mk_char(a0);
        n = 2'd1;
        cnt_a = cnt_a + CNT_W'(1);
      end else begin
        ovf_a = 1'b1;
      end
    end
    if (acc_n == 2'd2) begin
      if (cnt_a < CNT_W'(MAX_TOKEN)) begin
        nr[n[0]] = mk_char(a1);
        n = n + 2'd1;
        cnt_a = cnt_a + CNT_W'(1);
      end else begin
        ovf_a = 1'b1;
      end
    end
    if (do_end) begin
      nr[n[0]] = mk_end(end_type, ovf_a);
      n = n + 2'd1;
      cnt_a = '0;
      ovf_a = 1'b0;
    end
  end

  assign step       = cur_valid && room;
  assign final_step = step && !saved_mode && (ret == F_DONE);
  assign full       = cur_valid && !final_step;

  // The newest result is held back until it is known whether the word ends there.
  always_comb begin
    lst  = '0;
    lcnt = 2'd0;
    if (hold_valid) begin
      lst[0] = hold;
      lcnt = 2'd1;
    end
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < n) begin
        lst[lcnt] = nr[i];
        lcnt = lcnt + 2'd1;
      end
    end
    wr.count        = 2'd0;
    hold_next       = hold;
    hold_valid_next = hold_valid;
    if (step) begin
      if (final_step) begin
        if (lcnt != 2'd0) begin
          lst[lcnt - 2'd1].last = 1'b1;
        end
        wr.count        = lcnt;
        hold_valid_next = 1'b0;
      end else if (lcnt != 2'd0) begin
        wr.count        = lcnt - 2'd1;
        hold_next       = lst[lcnt - 2'd1];
        hold_valid_next = 1'b1;
      end
    end
    wr.data = lst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      st         <= S_START;
      cnt        <= '0;
      ovf        <= 1'b0;
      ecl        <= CLS_ILLEGAL;
      saved_mode <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (push && !full) begin
        cur_valid <= 1'b1;
      end else if (final_step) begin
        cur_valid <= 1'b0;
      end
      hold_valid <= hold_valid_next;
      if (step) begin
        st         <= do_end ? S_START : st_dec;
        cnt        <= cnt_a;
        ovf        <= ovf_a;
        saved_mode <= !saved_mode && (ret == F_SAVED);
        if (ecl_set) begin
          ecl <= fcls;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      cur <= item;
    end
    hold <= hold_next;
    if (step && sv_set) begin
      saved_char  <= sv_char;
      saved_class <= sv_class;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !cur_valid |-> !hold_valid)
    else $error("held result without a word in progress");
  assert property (@(posedge clk) disable iff (rst) cnt <= CNT_W'(MAX_TOKEN))
    else $error("token count beyond limit");
  assert property (@(posedge clk) disable iff (rst) ovf |-> (cnt == CNT_W'(MAX_TOKEN)))
    else $error("overflow flag set below the limit");
  assert property (@(posedge clk) disable iff (rst) saved_mode |-> (st == S_START))
    else $error("pushed-back character outside the start state");

endmodule

### rtl/pts_queue.sv
// Result queue: takes up to three words a cycle from the scanner, hands out one.
module pts_queue (
  input  logic          clk,
  input  logic          rst,
  input  pts_pkg::wr_t  wr,
  output logic          room,
  output logic          empty,
  input  logic          pop,
  output pts_pkg::res_t result
);
  import pts_pkg::*;

  res_t           mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   cnt;
  logic           pop_ok;

  assign pop_ok = pop && !empty;
  assign empty  = (cnt == '0);
  assign room   = (cnt <= (QAW+1)'(QDEPTH - WR_MAX));
  assign result = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      wptr <= wptr + QAW'(wr.count);
      rptr <= rptr + QAW'(pop_ok);
      cnt  <= cnt + (QAW+1)'(wr.count) - (QAW+1)'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WR_MAX; i++) begin
      if (2'(i) < wr.count) begin
        mem[wptr + QAW'(i)] <= wr.data[i];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= (QAW+1)'(QDEPTH))
    else $error("result queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
      (wr.count != 2'd0) |-> (cnt <= (QAW+1)'(QDEPTH - WR_MAX)))
    else $error("write without room");
  assert property (@(posedge clk) disable iff (rst)
      (empty && wr.count == 2'd0) |=> (cnt == $past(cnt)))
    else $error("pop from empty queue changed the fill");

endmodule

### verif/tb_prolog_token_scanner.sv
// Self-checking testbench for prolog_token_scanner with its own scanner model.
module tb_prolog_token_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import pts_pkg::*;

  localparam int RES_MAX    = 6;
  localparam int PASS_LIMIT = 16;
  localparam int RAND_ITEMS = 136;
  localparam int DRAIN_WAIT = 20;

  typedef enum logic [1:0] {PASS_DONE, PASS_AGAIN, PASS_BACK} pass_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  push = 1'b0;
  logic  pop = 1'b0;
  item_t item = '0;
  logic  full;
  logic  empty;
  res_t  result;

  item_t char_q[$];
  res_t  scanned_q[$];
  res_t  step_res[$];

  scan_state_t sc_state = S_START;
  int unsigned tok_len = 0;
  logic        tok_over = 1'b0;
  logic [2:0]  exp_cls = '0;
  logic [7:0]  back_ch = '0;
  logic [2:0]  back_cls = '0;

  int fail_count = 0;
  int tx_gap = 0;
  int tx_quiet = 0;
  int rx_gap = 0;
  int rx_quiet = 0;

  prolog_token_scanner u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void emit_char(input logic [7:0] ch);
    res_t r;
    if (tok_len < MAX_TOKEN) begin
      tok_len++;
      r = '0;
      r.result_kind = RK_CHAR;
      r.out_char = ch;
      if (step_res.size() < RES_MAX) step_res.push_back(r);
    end else begin
      tok_over = 1'b1;
    end
  endfunction

  function automatic void close_token(input logic [3:0] typ);
    res_t r;
    r = '0;
    r.result_kind = RK_END;
    r.token_type = typ;
    r.truncated = tok_over;
    if (step_res.size() < RES_MAX) step_res.push_back(r);
    tok_len = 0;
    tok_over = 1'b0;
    sc_state = S_START;
  endfunction

  function automatic pass_t scan_pass(input logic [7:0] ch, input logic [2:0] cls,
                                      input logic eoi);
    case (sc_state)
      S_IDENT: begin
        if (!eoi && (cls == CLS_WORD || cls == CLS_DIGIT)) begin
          emit_char(ch);
          return PASS_DONE;
        end
        close_token(TOK_WORD);
        return PASS_AGAIN;
      end
      S_SLASH: begin
        if (!eoi && ch == CH_STAR) begin
          sc_state = S_COMM;
          return PASS_DONE;
        end
        emit_char(CH_SLASH);
        sc_state = S_SYMB;
        return PASS_AGAIN;
      end
      S_SYMB: begin
        if (!eoi && cls == CLS_SYMBOL) begin
          emit_char(ch);
          return PASS_DONE;
        end
        close_token(TOK_SYMBOL);
        return PASS_AGAIN;
      end
      S_LCOMM: begin
        if (eoi) begin
          sc_state = S_START;
          return PASS_AGAIN;
        end
        if (ch == CH_NL) sc_state = S_START;
        return PASS_DONE;
      end
      S_COMM: begin
        if (eoi) begin
          sc_state = S_START;
          return PASS_AGAIN;
        end
        if (ch == CH_STAR) sc_state = S_CSTAR;
        return PASS_DONE;
      end
      S_CSTAR: begin
        if (eoi) begin
          sc_state = S_START;
          return PASS_AGAIN;
        end
        sc_state = (ch == CH_SLASH) ? S_START : S_COMM;
        return PASS_DONE;
      end
      S_QATOM: begin
        if (eoi) begin
          close_token(TOK_ILLEGAL);
          return PASS_AGAIN;
        end
        if (cls == CLS_QUOTE) sc_state = S_QQUOTE;
        else emit_char(ch);
        return PASS_DONE;
      end
      S_QQUOTE: begin
        if (!eoi && ch == CH_QUOTE) begin
          emit_char(ch);
          sc_state = S_QATOM;
          return PASS_DONE;
        end
        close_token(TOK_QUOTED);
        return PASS_AGAIN;
      end
      S_STRING: begin
        if (eoi) begin
          close_token(TOK_ILLEGAL);
          return PASS_AGAIN;
        end
        if (cls == CLS_STRDEL) close_token(TOK_STRING);
        else if (cls == CLS_SYMBOL && ch == CH_BSLASH) sc_state = S_SESC;
        else emit_char(ch);
        return PASS_DONE;
      end
      S_SESC: begin
        if (eoi) begin
          close_token(TOK_ILLEGAL);
          return PASS_AGAIN;
        end
        case (ch)
          CH_LB: emit_char(CH_BEL);
          CH_LN: emit_char(CH_NL);
          CH_LT: emit_char(CH_TAB);
          default: emit_char(ch);
        endcase
        sc_state = S_STRING;
        return PASS_DONE;
      end
      S_INT: begin
        if (!eoi) begin
          if (cls == CLS_DIGIT) begin
            emit_char(ch);
            return PASS_DONE;
          end
          if (cls == CLS_SYMBOL && ch == CH_DOT) begin
            sc_state = S_FRAC;
            return PASS_DONE;
          end
          if ((cls == CLS_SYMBOL || cls == CLS_WORD) && (ch == CH_LE || ch == CH_UE)) begin
            exp_cls = cls;
            sc_state = S_E;
            return PASS_DONE;
          end
        end
        close_token(TOK_INT);
        return PASS_AGAIN;
      end
      S_FRAC: begin
        if (!eoi && cls == CLS_DIGIT) begin
          emit_char(CH_DOT);
          emit_char(ch);
          sc_state = S_REAL;
          return PASS_DONE;
        end
        close_token(TOK_INT);
        back_ch = CH_DOT;
        back_cls = CLS_SYMBOL;
        return PASS_BACK;
      end
      S_REAL: begin
        if (!eoi) begin
          if (cls == CLS_DIGIT) begin
            emit_char(ch);
            return PASS_DONE;
          end
          if (cls == CLS_WORD && (ch == CH_LE || ch == CH_UE)) begin
            exp_cls = cls;
            sc_state = S_E;
            return PASS_DONE;
          end
        end
        close_token(TOK_REAL);
        return PASS_AGAIN;
      end
      S_E: begin
        if (!eoi && cls == CLS_DIGIT) begin
          emit_char(CH_LE);
          emit_char(ch);
          sc_state = S_EXPRST;
          return PASS_DONE;
        end
        if (!eoi && cls == CLS_SYMBOL && (ch == CH_PLUS || ch == CH_MINUS)) begin
          emit_char(CH_LE);
          emit_char(ch);
          sc_state = S_EXP;
          return PASS_DONE;
        end
        close_token(TOK_REAL);
        back_ch = CH_LE;
        back_cls = exp_cls;
        return PASS_BACK;
      end
      S_EXP: begin
        if (!eoi && cls == CLS_DIGIT) begin
          emit_char(ch);
          sc_state = S_EXPRST;
          return PASS_DONE;
        end
        close_token(TOK_ILLEGAL);
        return eoi ? PASS_AGAIN : PASS_DONE;
      end
      S_EXPRST: begin
        if (!eoi && cls == CLS_DIGIT) begin
          emit_char(ch);
          return PASS_DONE;
        end
        close_token(TOK_REAL);
        return PASS_AGAIN;
      end
      default: begin
        sc_state = S_START;
        if (eoi) begin
          close_token(TOK_END);
          return PASS_DONE;
        end
        case (cls)
          CLS_WORD: begin
            emit_char(ch);
            sc_state = S_IDENT;
          end
          CLS_DIGIT: begin
            emit_char(ch);
            sc_state = S_INT;
          end
          CLS_SYMBOL: begin
            if (ch == CH_PCT) sc_state = S_LCOMM;
            else if (ch == CH_SLASH) sc_state = S_SLASH;
            else begin
              emit_char(ch);
              sc_state = S_SYMB;
            end
          end
          CLS_PUNCT: begin
            emit_char(ch);
            close_token(TOK_PUNCT);
          end
          CLS_QUOTE: sc_state = S_QATOM;
          CLS_STRDEL: sc_state = S_STRING;
          CLS_SPACE: ;
          default: close_token(TOK_ILLEGAL);
        endcase
        return PASS_DONE;
      end
    endcase
  endfunction

  function automatic void scan_item(input item_t it);
    pass_t p;
    res_t  r;
    int    g;
    step_res.delete();
    for (g = 0; g < PASS_LIMIT; g++) begin
      p = scan_pass(it.in_char, it.char_class, it.end_of_input);
      if (p == PASS_DONE) break;
      if (p == PASS_BACK) void'(scan_pass(back_ch, back_cls, 1'b0));
    end
    if (step_res.size() != 0) begin
      r = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
    end
    foreach (step_res[i]) scanned_q.push_back(step_res[i]);
  endfunction

  function automatic void put_ch(input logic [7:0] ch, input logic [2:0] cls);
    item_t it;
    it.in_char = ch;
    it.char_class = cls;
    it.end_of_input = 1'b0;
    char_q.push_back(it);
  endfunction

  function automatic void put_eoi();
    item_t it;
    it.in_char = 8'($urandom_range(0, 255));
    it.char_class = 3'($urandom_range(0, 7));
    it.end_of_input = 1'b1;
    char_q.push_back(it);
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(97, 122));
  endfunction

  function automatic void put_digits(input int n);
    for (int i = 0; i < n; i++) put_ch(8'($urandom_range(48, 57)), CLS_DIGIT);
  endfunction

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void put_exp_letter();
    if ($urandom_range(0, 1) == 0) put_ch(CH_LE, CLS_WORD);
    else put_ch(CH_UE, ($urandom_range(0, 1) == 0) ? CLS_WORD : CLS_SYMBOL);
  endfunction

  function automatic void gen_token();
    int         k;
    int         n;
    logic [2:0] c;
    k = $urandom_range(0, 99);
    n = $urandom_range(0, 5);
    if (k < 14) begin
      put_ch(rand_letter(), CLS_WORD);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 2) == 0) put_digits(1);
        else put_ch(rand_letter(), CLS_WORD);
      end
    end else if (k < 22) begin
      for (int i = 0; i <= n % 3; i++) put_ch(pick("+-*<>=~:?@#&$^./\\"), CLS_SYMBOL);
    end else if (k < 28) begin
      put_ch(pick("(),;|[]{}!"), CLS_PUNCT);
    end else if (k < 38) begin
      put_ch(CH_QUOTE, CLS_QUOTE);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          put_ch(CH_QUOTE, CLS_QUOTE);
          put_ch(CH_QUOTE, 3'($urandom_range(0, 7)));
        end else begin
          c = 3'($urandom_range(0, 6));
          if (c == CLS_QUOTE) c = CLS_SPACE;
          put_ch(8'($urandom_range(0, 255)), c);
        end
      end
      put_ch(CH_QUOTE, CLS_QUOTE);
    end else if (k < 50) begin
      put_ch("\"", CLS_STRDEL);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          put_ch(CH_BSLASH, CLS_SYMBOL);
          put_ch(pick("bntbntx\\\"q"), 3'($urandom_range(0, 7)));
        end else begin
          c = 3'($urandom_range(0, 7));
          if (c == CLS_STRDEL) c = CLS_WORD;
          put_ch(8'($urandom_range(0, 255)), c);
        end
      end
      put_ch("\"", CLS_STRDEL);
    end else if (k < 70) begin
      put_digits($urandom_range(1, 3));
      case ($urandom_range(0, 5))
        1: begin
          put_ch(CH_DOT, CLS_SYMBOL);
          put_digits($urandom_range(1, 3));
        end
        2: begin
          put_ch(CH_DOT, CLS_SYMBOL);
          put_digits($urandom_range(1, 2));
          put_exp_letter();
          if ($urandom_range(0, 1) == 0) put_ch(pick("+-"), CLS_SYMBOL);
          put_digits($urandom_range(1, 2));
        end
        3: begin
          put_ch(CH_DOT, CLS_SYMBOL);
          put_ch(rand_letter(), CLS_WORD);
        end
        4: begin
          put_exp_letter();
          put_ch(pick(" \t"), CLS_SPACE);
        end
        5: begin
          put_exp_letter();
          put_ch(pick("+-"), CLS_SYMBOL);
          put_ch(rand_letter(), CLS_WORD);
        end
        default: ;
      endcase
    end else if (k < 76) begin
      if ($urandom_range(0, 1) == 0) begin
        put_ch(CH_PCT, CLS_SYMBOL);
        for (int i = 0; i < n; i++) put_ch(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
        put_ch(CH_NL, CLS_SPACE);
      end else begin
        put_ch(CH_SLASH, CLS_SYMBOL);
        put_ch(CH_STAR, CLS_SYMBOL);
        for (int i = 0; i < n; i++) put_ch(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 1) == 0) begin
          put_ch(CH_STAR, CLS_SYMBOL);
          put_ch(rand_letter(), CLS_WORD);
        end
        put_ch(CH_STAR, CLS_SYMBOL);
        put_ch(CH_SLASH, CLS_SYMBOL);
      end
    end else if (k < 86) begin
      put_ch(pick(" \t\n"), CLS_SPACE);
    end else if (k < 97) begin
      put_ch(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    end else begin
      put_eoi();
    end
    if ($urandom_range(0, 1) == 0) put_ch(pick(" \t\n"), CLS_SPACE);
  endfunction

  always @(posedge clk) begin : driver
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        scan_item(item);
        tx_gap = pick_gap(tx_quiet);
      end
      if (!push || !full) begin
        if (tx_gap > 0) begin
          push <= 1'b0;
          tx_gap--;
        end else if (char_q.size() != 0) begin
          push <= 1'b1;
          item <= char_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    res_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (scanned_q.size() == 0) begin
          flag_error($sformatf("unexpected result word %h", result));
        end else begin
          want = scanned_q.pop_front();
          if (result.result_kind !== want.result_kind || result.out_char !== want.out_char ||
              result.token_type !== want.token_type || result.truncated !== want.truncated ||
              result.last !== want.last) begin
            flag_error($sformatf({"result mismatch: expected kind %0d char %h type %0d ",
                                  "trunc %0d last %0d, got kind %0d char %h type %0d ",
                                  "trunc %0d last %0d"},
                                 want.result_kind, want.out_char, want.token_type,
                                 want.truncated, want.last, result.result_kind,
                                 result.out_char, result.token_type, result.truncated,
                                 result.last));
          end
        end
        rx_gap = pick_gap(rx_quiet);
      end
      if (rx_gap > 0) begin
        pop <= 1'b0;
        rx_gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int base;
    put_eoi();
    put_ch(CH_SLASH, CLS_SYMBOL);
    put_ch(CH_PLUS, CLS_SYMBOL);
    repeat (4) put_ch(CH_QUOTE, CLS_QUOTE);
    put_ch("(", CLS_PUNCT);
    put_ch("\"", CLS_STRDEL);
    put_ch(CH_BSLASH, CLS_SYMBOL);
    put_ch(CH_LB, CLS_WORD);
    put_ch(CH_BSLASH, CLS_SYMBOL);
    put_ch(CH_LN, CLS_WORD);
    put_ch(CH_BSLASH, CLS_SYMBOL);
    put_ch(CH_LT, CLS_WORD);
    put_ch("\"", CLS_STRDEL);
    put_ch("4", CLS_DIGIT);
    put_ch(CH_LE, CLS_WORD);
    put_ch(CH_PLUS, CLS_SYMBOL);
    put_ch("z", CLS_WORD);
    put_ch("9", CLS_DIGIT);
    put_ch(CH_DOT, CLS_SYMBOL);
    put_eoi();
    put_ch("2", CLS_DIGIT);
    put_ch(CH_UE, CLS_SYMBOL);
    put_eoi();
    put_ch("6", CLS_DIGIT);
    put_ch(CH_LE, CLS_WORD);
    put_ch(CH_MINUS, CLS_SYMBOL);
    put_eoi();
    put_ch(8'h00, CLS_ILLEGAL);
    put_ch(8'hff, CLS_WORD);
    put_ch(" ", CLS_SPACE);
    base = char_q.size();
    while (char_q.size() < base + RAND_ITEMS) gen_token();
    put_eoi();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk); while (char_q.size() != 0 || push || scanned_q.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("** prolog_token_scanner: PASSED **");
    end else begin
      $display("** prolog_token_scanner: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("** prolog_token_scanner: FAILED **");
    $finish;
  end

endmodule
